// File: src/emv_pkg.sv
// ----------------------------------------------------------------------------
// emv_pkg
// Shared constants and types for the ease-of-movement indicator unit.
// ----------------------------------------------------------------------------
package emv_pkg;

   localparam int MaxWindowDefault    = 64;
   localparam int FractionBitsDefault = 16;

   localparam int PriceW   = 32;
   localparam int VolumeW  = 48;
   localparam int ValueW   = 48;
   localparam int LenW     = 7;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   localparam logic [LenW-1:0] WindowLenReset = 7'd14;
   localparam logic [LenW-1:0] SignalLenReset = 7'd9;

   localparam logic [CsrAddrW-1:0] AddrWindowLen = 3'd0;
   localparam logic [CsrAddrW-1:0] AddrSignalLen = 3'd4;

   localparam int MidScale = 100;

   // Divider job: floor(num / den), num up to 128 bits, den up to 64 bits.
   localparam int NumW = 128;
   localparam int DenW = 64;

   typedef struct packed {
      logic            start;
      logic [NumW-1:0] num;
      logic [DenW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [NumW-1:0] quo;
   } div_rsp_type;

endpackage

// File: src/emv_if.sv
// ----------------------------------------------------------------------------
// emv_req_if / emv_rsp_if
// Valid/ready channels for price bars and indicator results.
// ----------------------------------------------------------------------------
interface emv_req_if;
   logic                          valid;
   logic                          ready;
   logic [emv_pkg::PriceW-1:0]    high_price;
   logic [emv_pkg::PriceW-1:0]    low_price;
   logic [emv_pkg::VolumeW-1:0]   volume;
   logic                          restart;

   modport source (output valid, high_price, low_price, volume, restart, input ready);
   modport sink   (input valid, high_price, low_price, volume, restart, output ready);
endinterface

interface emv_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [emv_pkg::ValueW-1:0]  emv_value;
   logic signed [emv_pkg::ValueW-1:0]  emv_average;
   logic                               status;

   modport source (output valid, emv_value, emv_average, status, input ready);
   modport sink   (input valid, emv_value, emv_average, status, output ready);
endinterface

// File: src/ease_of_movement_indicator_unit.sv
// ----------------------------------------------------------------------------
// ease_of_movement_indicator_unit
// Ease-of-movement value and its moving average over windowed ring sums.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | high_price, low_price, volume, restart
//  rsp     | out | valid/ready        | emv_value, emv_average, status
//  csr     | in  | APB psel/penable   | window_length @0x0, signal_length @0x4
//
// A bar goes from its accepting edge to rsp_valid through five quotients
// on one bit-serial divider (start, 128 quotient bits, done), two 64x64
// products as four 32x32 multiply passes each, and ring reads, sums and
// hand-offs. A zero divisor finishes its quotient without the bit loop.
// After reset a clearing pass over all MAX_WINDOW entries zeroes the rings;
// a bar with restart set runs the same pass first. req_ready is low while
// a bar is in work or a result waits on rsp.
// ----------------------------------------------------------------------------
module ease_of_movement_indicator_unit #(
   parameter int MAX_WINDOW    = emv_pkg::MaxWindowDefault,
   parameter int FRACTION_BITS = emv_pkg::FractionBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   emv_req_if.sink                         req,
   emv_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [emv_pkg::CsrAddrW-1:0]    csr_paddr,
   input  logic [emv_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic [emv_pkg::CsrDataW-1:0]    csr_prdata,
   output logic                            csr_pready
);
   localparam int PW  = $clog2(MAX_WINDOW);
   localparam int LW  = emv_pkg::LenW;
   localparam int VW  = emv_pkg::ValueW;
   localparam int NW  = emv_pkg::NumW;
   localparam int DW  = emv_pkg::DenW;
   localparam int SVW = emv_pkg::VolumeW + PW;
   localparam int SRW = emv_pkg::PriceW + PW;
   localparam int SQW = VW + PW;
   localparam logic [63:0] SatMax = 64'h0000_7FFF_FFFF_FFFF;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_READ, S_SUMS, S_VF_GO, S_VF_WAIT, S_MID_MUL, S_MID_GO,
      S_MID_WAIT, S_T_GO, S_WM_ISSUE, S_WM_ACC, S_T_CAP, S_RW_MUL, S_RW_MUL2,
      S_TERM_MUL, S_TERM_GO, S_TERM_WAIT, S_EMV_GO, S_EMV_WAIT, S_ES_READ,
      S_AVG_GO, S_AVG_WAIT, S_OUT
   } state_type;

   // ---------------- configuration ----------------
   logic [LW-1:0] wlen_ff, slen_ff;
   logic          csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= emv_pkg::WindowLenReset;
         slen_ff <= emv_pkg::SignalLenReset;
      end else if (csr_wr) begin
         unique case (csr_paddr)
            emv_pkg::AddrWindowLen: wlen_ff <= csr_pwdata[LW-1:0];
            emv_pkg::AddrSignalLen: slen_ff <= csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         emv_pkg::AddrWindowLen: csr_prdata = {{(emv_pkg::CsrDataW-LW){1'b0}}, wlen_ff};
         emv_pkg::AddrSignalLen: csr_prdata = {{(emv_pkg::CsrDataW-LW){1'b0}}, slen_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // clamped lengths, PW+1 bits
   logic [PW:0] w_len, s_len;
   always_comb begin
      if (wlen_ff == '0)                   w_len = (PW+1)'(1);
      else if (32'(wlen_ff) > MAX_WINDOW)  w_len = (PW+1)'(MAX_WINDOW);
      else                                 w_len = (PW+1)'(wlen_ff);
      if (slen_ff == '0)                   s_len = (PW+1)'(1);
      else if (32'(slen_ff) > MAX_WINDOW)  s_len = (PW+1)'(MAX_WINDOW);
      else                                 s_len = (PW+1)'(slen_ff);
   end

   // ---------------- ring memories ----------------
   logic [47:0]         vol_mem   [MAX_WINDOW];
   logic [31:0]         rng_mem   [MAX_WINDOW];
   logic signed [47:0]  ratio_mem [MAX_WINDOW];
   logic signed [47:0]  emvr_mem  [MAX_WINDOW];
   logic [47:0]         vol_rd;
   logic [31:0]         rng_rd;
   logic signed [47:0]  ratio_rd, emvr_rd;

   logic                w_we, s_we;
   logic [PW-1:0]       w_addr, s_addr;
   logic [47:0]         vol_wd;
   logic [31:0]         rng_wd;
   logic signed [47:0]  ratio_wd, emvr_wd;

   always_ff @(posedge clock) begin
      if (w_we) begin
         vol_mem[w_addr]   <= vol_wd;
         rng_mem[w_addr]   <= rng_wd;
         ratio_mem[w_addr] <= ratio_wd;
      end
      if (s_we) emvr_mem[s_addr] <= emvr_wd;
      vol_rd   <= vol_mem[w_addr];
      rng_rd   <= rng_mem[w_addr];
      ratio_rd <= ratio_mem[w_addr];
      emvr_rd  <= emvr_mem[s_addr];
   end

   // ---------------- shared units ----------------
   emv_pkg::div_req_type div_req;
   emv_pkg::div_rsp_type div_rsp;
   emv_divider u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   emv_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));

   // ---------------- datapath state ----------------
   state_type            state_ff, state_in;
   logic [PW:0]          clr_ff, clr_in;
   logic [PW-1:0]        wpos_ff, wpos_in, spos_ff, spos_in;
   logic [SVW-1:0]       vtot_ff, vtot_in;
   logic [SRW-1:0]       rtot_ff, rtot_in;
   logic signed [SQW-1:0] qtot_ff, qtot_in, etot_ff, etot_in;
   logic [31:0]          ph_ff, ph_in, pl_ff, pl_in;
   logic [31:0]          hi_ff, hi_in, lo_ff, lo_in;
   logic [47:0]          vol_ff, vol_in;
   logic [31:0]          rng_ff, rng_in;
   logic                 neg_ff, neg_in, stat_ff, stat_in, rst_ff, rst_in;
   logic [63:0]          vf_ff, vf_in, mm_ff, mm_in, t_ff, t_in, rw_ff, rw_in;
   logic signed [VW-1:0] emv_ff, emv_in, avg_ff, avg_in;
   logic                 out_v_ff, out_v_in;
   logic [NW-1:0]        acc_ff, acc_in;
   logic [1:0]           part_ff, part_in;
   logic                 wm_term_ff, wm_term_in;

   logic [32:0]  hl, phl;
   logic [32:0]  dmag;
   logic [63:0]  cap;
   logic [63:0]  qsat;
   logic [63:0]  tot_mag;
   logic         tot_neg;
   logic [63:0]  wa, wb;
   logic [NW-1:0] tprod;

   assign hl   = {1'b0, hi_ff} + {1'b0, lo_ff};
   assign phl  = {1'b0, ph_ff} + {1'b0, pl_ff};
   assign dmag = neg_ff ? phl - hl : hl - phl;
   assign cap  = neg_ff ? SatMax + 64'd1 : SatMax;
   // cap the quotient (covers hi >= d in the model as well)
   assign qsat = (div_rsp.quo > {64'd0, cap}) ? cap : div_rsp.quo[63:0];
   // wide product operands: MID x VF first, then T x range*W
   assign wa    = wm_term_ff ? t_ff  : mm_ff;
   assign wb    = wm_term_ff ? rw_ff : vf_ff;
   assign tprod = acc_ff >> FRACTION_BITS;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      wpos_in  = wpos_ff;  spos_in = spos_ff;
      vtot_in  = vtot_ff;  rtot_in = rtot_ff;
      qtot_in  = qtot_ff;  etot_in = etot_ff;
      ph_in    = ph_ff;    pl_in   = pl_ff;
      hi_in    = hi_ff;    lo_in   = lo_ff;
      vol_in   = vol_ff;   rng_in  = rng_ff;
      neg_in   = neg_ff;   stat_in = stat_ff;  rst_in = rst_ff;
      vf_in    = vf_ff;    mm_in   = mm_ff;    t_in = t_ff;  rw_in = rw_ff;
      emv_in   = emv_ff;   avg_in  = avg_ff;
      out_v_in = out_v_ff;
      acc_in   = acc_ff;   part_in = part_ff;  wm_term_in = wm_term_ff;
      w_we = 1'b0;  s_we = 1'b0;
      w_addr = wpos_ff;  s_addr = spos_ff;
      vol_wd = vol_ff;  rng_wd = rng_ff;  ratio_wd = '0;  emvr_wd = emv_ff;
      div_req = '0;
      mul_a = '0;  mul_b = '0;
      tot_neg = 1'b0;  tot_mag = '0;

      unique case (state_ff)
         S_CLEAR: begin
            w_we = 1'b1;  s_we = 1'b1;
            w_addr = clr_ff[PW-1:0];  s_addr = clr_ff[PW-1:0];
            vol_wd = '0;  rng_wd = '0;  ratio_wd = '0;  emvr_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (PW+1)'(MAX_WINDOW - 1)) begin
               vtot_in = '0;  rtot_in = '0;  qtot_in = '0;  etot_in = '0;
               ph_in = '0;  pl_in = '0;  wpos_in = '0;  spos_in = '0;
               state_in = rst_ff ? S_READ : S_IDLE;
               rst_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               hi_in  = req.high_price;  lo_in = req.low_price;
               vol_in = req.volume;
               rng_in = (req.high_price > req.low_price) ?
                        req.high_price - req.low_price : '0;
               stat_in = 1'b0;
               if (req.restart) begin
                  rst_in = 1'b1;  clr_in = '0;  state_in = S_CLEAR;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // wrap positions beyond a shortened length
            if ({1'b0, wpos_ff} >= w_len) wpos_in = '0;
            if ({1'b0, spos_ff} >= s_len) spos_in = '0;
            w_addr = ({1'b0, wpos_ff} >= w_len) ? '0 : wpos_ff;
            s_addr = ({1'b0, spos_ff} >= s_len) ? '0 : spos_ff;
            state_in = S_SUMS;
         end
         S_SUMS: begin
            vtot_in = vtot_ff - SVW'(vol_rd) + SVW'(vol_ff);
            rtot_in = rtot_ff - SRW'(rng_rd) + SRW'(rng_ff);
            w_we = 1'b1;
            ratio_wd = ratio_rd;
            neg_in = phl > hl;
            state_in = S_VF_GO;
         end
         S_VF_GO: begin
            if (vol_ff == '0 || hl == '0 || rtot_ff == '0) stat_in = 1'b1;
            div_req.start = 1'b1;
            div_req.num   = NW'(vtot_ff) << FRACTION_BITS;
            div_req.den   = DW'(vol_ff) * DW'(w_len);
            state_in = S_VF_WAIT;
         end
         S_VF_WAIT: begin
            if (div_rsp.done) begin
               vf_in = (div_rsp.quo > {64'd0, SatMax}) ? SatMax : div_rsp.quo[63:0];
               state_in = S_MID_MUL;
            end
         end
         S_MID_MUL: begin
            mul_a = dmag[31:0];  mul_b = 32'(emv_pkg::MidScale);
            state_in = S_MID_GO;
         end
         S_MID_GO: begin
            // top bit of dmag scaled by 100 added back
            div_req.start = 1'b1;
            div_req.num   = (NW'(mul_p) + (dmag[32] ? (NW'(emv_pkg::MidScale) << 32) : '0))
                            << FRACTION_BITS;
            div_req.den   = DW'(hl);
            state_in = S_MID_WAIT;
         end
         S_MID_WAIT: begin
            if (div_rsp.done) begin
               mm_in = qsat;  state_in = S_T_GO;
            end
         end
         S_T_GO: begin
            acc_in = '0;  part_in = '0;  wm_term_in = 1'b0;
            state_in = S_WM_ISSUE;
         end
         S_WM_ISSUE: begin
            mul_a = part_ff[0] ? wa[63:32] : wa[31:0];
            mul_b = part_ff[1] ? wb[63:32] : wb[31:0];
            state_in = S_WM_ACC;
         end
         S_WM_ACC: begin
            // weight each partial product by 2^(32 * number of high halves)
            acc_in  = acc_ff + (NW'(mul_p) << {part_ff[1] & part_ff[0],
                                               part_ff[1] ^ part_ff[0], 5'd0});
            part_in = part_ff + 2'd1;
            if (part_ff == 2'd3) state_in = wm_term_ff ? S_TERM_GO : S_T_CAP;
            else                 state_in = S_WM_ISSUE;
         end
         S_T_CAP: begin
            t_in = (tprod > {64'd0, cap}) ? cap : tprod[63:0];
            state_in = S_RW_MUL;
         end
         S_RW_MUL: begin
            mul_a = rng_ff;  mul_b = 32'(w_len);
            state_in = S_RW_MUL2;
         end
         S_RW_MUL2: begin
            rw_in = mul_p;  state_in = S_TERM_MUL;
         end
         S_TERM_MUL: begin
            acc_in = '0;  part_in = '0;  wm_term_in = 1'b1;
            state_in = S_WM_ISSUE;
         end
         S_TERM_GO: begin
            div_req.start = 1'b1;
            div_req.num   = acc_ff;
            div_req.den   = DW'(rtot_ff);
            state_in = S_TERM_WAIT;
         end
         S_TERM_WAIT: begin
            if (div_rsp.done) begin
               ratio_wd = neg_ff ? -$signed(48'(qsat)) : $signed(48'(qsat));
               w_we = 1'b1;
               qtot_in = qtot_ff - SQW'(ratio_rd) + SQW'(ratio_wd);
               state_in = S_EMV_GO;
            end
         end
         S_EMV_GO: begin
            tot_neg = qtot_ff[SQW-1];
            tot_mag = 64'(tot_neg ? -qtot_ff : qtot_ff);
            div_req.start = 1'b1;
            div_req.num   = NW'(tot_mag);
            div_req.den   = DW'(w_len);
            state_in = S_EMV_WAIT;
         end
         S_EMV_WAIT: begin
            if (div_rsp.done) begin
               if (qtot_ff[SQW-1])
                  emv_in = (div_rsp.quo > NW'(SatMax + 64'd1)) ? {1'b1, {(VW-1){1'b0}}}
                           : VW'(-$signed(div_rsp.quo[63:0]));
               else
                  emv_in = (div_rsp.quo > NW'(SatMax)) ? {1'b0, {(VW-1){1'b1}}}
                           : VW'(div_rsp.quo[63:0]);
               state_in = S_ES_READ;
            end
         end
         S_ES_READ: begin
            s_we = 1'b1;  emvr_wd = emv_ff;
            etot_in = etot_ff - SQW'(emvr_rd) + SQW'(emv_ff);
            state_in = S_AVG_GO;
         end
         S_AVG_GO: begin
            tot_neg = etot_ff[SQW-1];
            tot_mag = 64'(tot_neg ? -etot_ff : etot_ff);
            div_req.start = 1'b1;
            div_req.num   = NW'(tot_mag);
            div_req.den   = DW'(s_len);
            state_in = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (div_rsp.done) begin
               if (etot_ff[SQW-1])
                  avg_in = (div_rsp.quo > NW'(SatMax + 64'd1)) ? {1'b1, {(VW-1){1'b0}}}
                           : VW'(-$signed(div_rsp.quo[63:0]));
               else
                  avg_in = (div_rsp.quo > NW'(SatMax)) ? {1'b0, {(VW-1){1'b1}}}
                           : VW'(div_rsp.quo[63:0]);
               // advance ring positions, keep prices
               wpos_in = ({1'b0, wpos_ff} + 1'b1 >= w_len) ? '0 : wpos_ff + 1'b1;
               spos_in = ({1'b0, spos_ff} + 1'b1 >= s_len) ? '0 : spos_ff + 1'b1;
               ph_in = hi_ff;  pl_in = lo_ff;
               out_v_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               out_v_in = 1'b0;  state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         rst_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         wpos_ff  <= '0;  spos_ff <= '0;
         vtot_ff  <= '0;  rtot_ff <= '0;  qtot_ff <= '0;  etot_ff <= '0;
         ph_ff    <= '0;  pl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rst_ff   <= rst_in;
         out_v_ff <= out_v_in;
         wpos_ff  <= wpos_in;  spos_ff <= spos_in;
         vtot_ff  <= vtot_in;  rtot_ff <= rtot_in;
         qtot_ff  <= qtot_in;  etot_ff <= etot_in;
         ph_ff    <= ph_in;    pl_ff   <= pl_in;
      end
      hi_ff <= hi_in;  lo_ff <= lo_in;  vol_ff <= vol_in;  rng_ff <= rng_in;
      neg_ff <= neg_in;  stat_ff <= stat_in;
      vf_ff <= vf_in;  mm_ff <= mm_in;  t_ff <= t_in;  rw_ff <= rw_in;
      emv_ff <= emv_in;  avg_ff <= avg_in;
      acc_ff <= acc_in;  part_ff <= part_in;  wm_term_ff <= wm_term_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = out_v_ff;
   assign rsp.emv_value   = emv_ff;
   assign rsp.emv_average = avg_ff;
   assign rsp.status      = stat_ff;
endmodule

// File: src/emv_divider.sv
// ----------------------------------------------------------------------------
// emv_divider
// Restoring divider, one quotient bit per cycle; zero divisor gives zero.
// ----------------------------------------------------------------------------
module emv_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  emv_pkg::div_req_type req,
   output emv_pkg::div_rsp_type rsp
);
   localparam int NW = emv_pkg::NumW;
   localparam int DW = emv_pkg::DenW;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff,  busy_in;
   logic          done_ff,  done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] quo_ff,   quo_in;
   logic [DW:0]   rem_ff,   rem_in;
   logic [DW-1:0] den_ff,   den_in;
   logic [DW:0]   shifted;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      shifted  = {rem_ff[DW-1:0], quo_ff[NW-1]};
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = CW'(NW);
         quo_in   = req.num;
         rem_in   = '0;
         den_in   = req.den;
      end else if (busy_ff) begin
         if (den_ff == '0) begin
            quo_in  = '0;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            // shift in next dividend bit, subtract when it fits
            if (shifted >= {1'b0, den_ff}) begin
               rem_in = shifted - {1'b0, den_ff};
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            count_in = count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
endmodule

// File: src/emv_mul.sv
// ----------------------------------------------------------------------------
// emv_mul
// Shared 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module emv_mul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);
   logic [63:0] p_ff, p_in;

   assign p_in = {32'd0, a} * {32'd0, b};

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

// File: src/emv_checker.sv
// ----------------------------------------------------------------------------
// emv_checker
// Port-level checks on the ease-of-movement indicator unit.
// ----------------------------------------------------------------------------
module emv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_pready
);
   // a result and a new bar never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready)) else $error("ready while result pending");

   // accepted bar blocks the input next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");

   // a result beat clears valid
   a_drop_after_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid) else $error("result repeated");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready) else $error("pready low");
endmodule

bind ease_of_movement_indicator_unit emv_checker u_emv_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .csr_pready(csr_pready)
);
